/* sv/lpht_pkg.sv */
package lpht_pkg;

  // Default table geometry.
  localparam int TABLE_SLOTS = 16;
  localparam int KEY_BYTES   = 8;

  // Multiplier of the polynomial key hash.
  localparam logic [31:0] HASH_MULT = 32'd31;

  // Fixed field widths of the request and response.
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 64;
  localparam int LEN_W    = 4;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_EXISTS = 2'd1,
    MODE_GET    = 2'd2,
    MODE_REMOVE = 2'd3
  } lpht_mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } lpht_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } lpht_state_e;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_BYTES,
    HS_QUOT,
    HS_REDUCE
  } lpht_hash_state_e;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [KEY_W-1:0]          key_bytes;
    logic [LEN_W-1:0]          key_length;
    logic signed [VALUE_W-1:0] new_value;
  } lpht_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic                      found;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        entry_count;
  } lpht_rsp_t;

  // Start command for the hash unit: masked key and clamped length.
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } lpht_hash_cmd_t;

endpackage

/* sv/linear_probe_hash_table_unit.sv */
// Key-value table with open addressing and linear probing.
// Requests enter on in_req_i under in_valid_i / in_stall_o; a request is taken
// at a clock edge where in_valid_i is high and in_stall_o is low. Each request
// produces exactly one response on out_rsp_o under out_valid_o / out_stall_i.
// After reset the slot memory is cleared one slot per cycle, and in_stall_o
// stays high until every slot is cleared, before the first request is taken.
// One request is worked at a time, and the next request can be taken once its
// response is loaded into the output register. The hash takes the key bytes one
// at a time, the reduction modulo TABLE_SLOTS is a reciprocal multiplication
// followed by a multiply and subtract, and each probed slot costs a read and a
// check on the single read port of the slot memory.
// Add, exists and get stop at a match or an empty slot; remove always walks
// the ring until it finds its key, up to TABLE_SLOTS slots. A finished
// response is held in the output register while out_stall_i is high; the
// next request may be taken and worked meanwhile, but its response waits
// until the output register is free.
module linear_probe_hash_table_unit #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS,
  parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpht_pkg::lpht_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpht_pkg::lpht_rsp_t out_rsp_o
);

  localparam int IW  = $clog2(TABLE_SLOTS);
  localparam int CW  = $clog2(TABLE_SLOTS + 1);
  localparam int KW  = 8 * KEY_BYTES;
  localparam int LW  = lpht_pkg::LEN_W;
  localparam int VW  = lpht_pkg::VALUE_W;
  localparam int DW  = 1 + LW + KW + VW;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_SLOTS);

  lpht_pkg::lpht_state_e state_q, state_d;

  logic [lpht_pkg::MODE_W-1:0] mode_q;
  logic [lpht_pkg::KEY_W-1:0]  key_q;
  logic [LW-1:0]               len_q;
  logic [VW-1:0]               value_q;
  logic [IW-1:0]               idx_q, idx_d;
  logic [IW-1:0]               steps_q, steps_d;
  logic [CW-1:0]               count_q, count_d;

  logic [lpht_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic                          res_found_q, res_found_d;
  logic [VW-1:0]                 res_value_q, res_value_d;

  logic                out_valid_q;
  lpht_pkg::lpht_rsp_t out_rsp_q;

  logic                   accept;
  logic                   out_free;
  logic                   load_out;
  logic [LW-1:0]          len_c;
  logic [lpht_pkg::KEY_W-1:0] key_c;

  lpht_pkg::lpht_hash_cmd_t hash_cmd;
  logic                     hash_done;
  logic [IW-1:0]            hash_home;

  logic          mem_we;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [DW-1:0] mem_rdata;

  logic          ent_valid;
  logic [LW-1:0] ent_len;
  logic [KW-1:0] ent_key;
  logic [VW-1:0] ent_value;
  logic          ent_match;
  logic          last_step;
  logic [IW-1:0] idx_inc;

  // Clamp the key length and zero the bytes beyond it.
  always_comb begin
    len_c = (in_req_i.key_length > LW'(KEY_BYTES)) ? LW'(KEY_BYTES) : in_req_i.key_length;
    for (int j = 0; j < 8; j++) begin
      key_c[8*j +: 8] = (LW'(j) < len_c) ? in_req_i.key_bytes[8*j +: 8] : 8'h00;
    end
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != lpht_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign hash_cmd.start = accept;
  assign hash_cmd.key   = key_c;
  assign hash_cmd.len   = len_c;

  lpht_hash #(
    .SLOTS (TABLE_SLOTS)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (hash_cmd),
    .done_o (hash_done),
    .home_o (hash_home)
  );

  lpht_slot_mem #(
    .DEPTH  (TABLE_SLOTS),
    .DATA_W (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // Slot entry as read back from memory.
  assign {ent_valid, ent_len, ent_key, ent_value} = mem_rdata;
  assign ent_match = ent_valid && (ent_len == len_q) && (ent_key == key_q[KW-1:0]);
  assign last_step = (steps_q == LAST_IDX);
  assign idx_inc   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

  // Sequencer: clear pass, hash, then read and check one slot at a time.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    steps_d      = steps_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_value_d  = res_value_q;
    mem_we       = 1'b0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    load_out     = 1'b0;
    unique case (state_q)
      lpht_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        idx_d  = idx_inc;
        if (idx_q == LAST_IDX) begin
          state_d = lpht_pkg::ST_IDLE;
        end
      end
      lpht_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lpht_pkg::ST_HASH;
        end
      end
      lpht_pkg::ST_HASH: begin
        if (hash_done) begin
          idx_d        = hash_home;
          steps_d      = '0;
          res_status_d = lpht_pkg::STATUS_NOT_FOUND;
          res_found_d  = 1'b0;
          res_value_d  = '0;
          state_d      = lpht_pkg::ST_READ;
        end
      end
      lpht_pkg::ST_READ: begin
        mem_re  = 1'b1;
        state_d = lpht_pkg::ST_CHECK;
      end
      lpht_pkg::ST_CHECK: begin
        state_d = lpht_pkg::ST_DONE;
        if (mode_q == lpht_pkg::MODE_REMOVE) begin
          // Remove walks past empty slots until a match or a full turn.
          if (ent_match) begin
            mem_we       = 1'b1;
            mem_wdata    = {1'b0, mem_rdata[DW-2:0]};
            count_d      = (count_q != '0) ? count_q - 1'b1 : count_q;
            res_status_d = lpht_pkg::STATUS_OK;
            res_found_d  = 1'b1;
          end else if (!last_step) begin
            idx_d   = idx_inc;
            steps_d = steps_q + 1'b1;
            state_d = lpht_pkg::ST_READ;
          end
        end else if (ent_match) begin
          res_status_d = lpht_pkg::STATUS_OK;
          res_found_d  = 1'b1;
          if (mode_q == lpht_pkg::MODE_ADD) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, len_q, key_q[KW-1:0], value_q};
          end else if (mode_q == lpht_pkg::MODE_GET) begin
            res_value_d = ent_value;
          end
        end else if (!ent_valid) begin
          // First empty slot ends the search; add fills it.
          if (mode_q == lpht_pkg::MODE_ADD) begin
            if (count_q >= FULL_CNT) begin
              res_status_d = lpht_pkg::STATUS_FULL;
            end else begin
              mem_we       = 1'b1;
              mem_wdata    = {1'b1, len_q, key_q[KW-1:0], value_q};
              count_d      = count_q + 1'b1;
              res_status_d = lpht_pkg::STATUS_OK;
            end
          end
        end else if (last_step) begin
          // A full turn without an empty slot: add reports a full table.
          if (mode_q == lpht_pkg::MODE_ADD) begin
            res_status_d = lpht_pkg::STATUS_FULL;
          end
        end else begin
          idx_d   = idx_inc;
          steps_d = steps_q + 1'b1;
          state_d = lpht_pkg::ST_READ;
        end
      end
      lpht_pkg::ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = lpht_pkg::ST_IDLE;
        end
      end
      default: state_d = lpht_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpht_pkg::ST_CLEAR;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, result and output payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= in_req_i.mode;
      key_q   <= key_c;
      len_q   <= len_c;
      value_q <= in_req_i.new_value;
    end
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_value_q  <= res_value_d;
    if (load_out) begin
      out_rsp_q.status      <= res_status_q;
      out_rsp_q.found       <= res_found_q;
      out_rsp_q.read_value  <= res_value_q;
      out_rsp_q.entry_count <= lpht_pkg::COUNT_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

/* sv/lpht_slot_mem.sv */
module lpht_slot_mem #(
  parameter int DEPTH  = lpht_pkg::TABLE_SLOTS,
  parameter int DATA_W = 101
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lpht_hash.sv */
module lpht_hash #(
  parameter int SLOTS = lpht_pkg::TABLE_SLOTS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lpht_pkg::lpht_hash_cmd_t cmd_i,
  output logic                     done_o,
  output logic [$clog2(SLOTS)-1:0] home_o
);

  localparam int IW = $clog2(SLOTS);
  // Reciprocal of the slot count, ceil(2^(32+IW) / SLOTS). It lies in [2^32, 2^33),
  // so only its low word is multiplied and the leading one is added as h << 32.
  localparam logic [63:0] RECIP    = ((64'd1 << (32 + IW)) + 64'(SLOTS) - 64'd1)
                                     / 64'(SLOTS);
  localparam logic [31:0] RECIP_LO = RECIP[31:0];
  localparam logic [31:0] SLOTS_W  = 32'(SLOTS);

  lpht_pkg::lpht_hash_state_e state_q, state_d;

  logic [31:0]                 h_q, h_d;
  logic [lpht_pkg::KEY_W-1:0]  key_q, key_d;
  logic [lpht_pkg::LEN_W-1:0]  left_q, left_d;
  logic [31:0]                 quo_q, quo_d;
  logic [63:0]                 mul_lo;
  logic [64:0]                 prod;
  logic [31:0]                 rem_w;
  logic                        done_q, done_d;
  logic [IW-1:0]               home_q, home_d;

  // Quotient by reciprocal multiplication, then remainder by multiply and subtract.
  assign mul_lo = {32'd0, h_q} * {32'd0, RECIP_LO};
  assign prod   = {1'b0, h_q, 32'd0} + {1'b0, mul_lo};
  assign rem_w  = h_q - quo_q * SLOTS_W;

  // Byte loop of the hash, then reduction modulo the slot count.
  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    key_d   = key_q;
    left_d  = left_q;
    quo_d   = quo_q;
    done_d  = 1'b0;
    home_d  = home_q;
    unique case (state_q)
      lpht_pkg::HS_IDLE: begin
        if (cmd_i.start) begin
          h_d     = '0;
          key_d   = cmd_i.key;
          left_d  = cmd_i.len;
          state_d = lpht_pkg::HS_BYTES;
        end
      end
      lpht_pkg::HS_BYTES: begin
        if (left_q == '0) begin
          state_d = lpht_pkg::HS_QUOT;
        end else begin
          h_d    = 32'(h_q * lpht_pkg::HASH_MULT) + {24'd0, key_q[7:0]};
          key_d  = {8'd0, key_q[lpht_pkg::KEY_W-1:8]};
          left_d = left_q - 1'b1;
        end
      end
      lpht_pkg::HS_QUOT: begin
        quo_d   = 32'(prod >> (32 + IW));
        state_d = lpht_pkg::HS_REDUCE;
      end
      lpht_pkg::HS_REDUCE: begin
        done_d  = 1'b1;
        home_d  = rem_w[IW-1:0];
        state_d = lpht_pkg::HS_IDLE;
      end
      default: state_d = lpht_pkg::HS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpht_pkg::HS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    key_q  <= key_d;
    left_q <= left_d;
    quo_q  <= quo_d;
    home_q <= home_d;
  end

  assign done_o = done_q;
  assign home_o = home_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 100;
  localparam int IDLE_PCT     = 37;
  localparam int POOL_DEPTH   = 32;
  localparam int CALM_FIRST   = 700;
  localparam int CALM_LAST    = 1000;
  localparam int TABLE_SLOTS  = lpht_pkg::TABLE_SLOTS;
  localparam int KEY_BYTES    = lpht_pkg::KEY_BYTES;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  lpht_pkg::lpht_req_t in_req_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  lpht_pkg::lpht_rsp_t out_rsp_o;

  // Shadow copy of the slot memory and the occupancy counter.
  logic        kv_valid [TABLE_SLOTS];
  logic [63:0] kv_key   [TABLE_SLOTS];
  logic [3:0]  kv_len   [TABLE_SLOTS];
  logic [31:0] kv_val   [TABLE_SLOTS];
  int unsigned kv_count = 0;

  // Keys that the random traffic draws from, so that requests hit earlier ones.
  logic [63:0] pool_key [POOL_DEPTH];
  logic [3:0]  pool_len [POOL_DEPTH];

  lpht_pkg::lpht_req_t pending_reqs[$];
  lpht_pkg::lpht_rsp_t expected_rsps[$];
  int unsigned req_count   = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          taken_last  = 1'b0;
  logic        calm_phase;

  assign calm_phase = (req_count >= CALM_FIRST) && (req_count < CALM_LAST);

  linear_probe_hash_table_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Home slot: polynomial hash over the valid key bytes, 32-bit wraparound.
  function automatic int key_home(logic [63:0] key, int len);
    logic [31:0] h;
    h = '0;
    for (int b = 0; b < len; b++) h = h * lpht_pkg::HASH_MULT + {24'd0, key[8*b +: 8]};
    return int'(h % 32'(TABLE_SLOTS));
  endfunction

  function automatic bit key_at(int s, logic [63:0] key, int len);
    return kv_valid[s] && (kv_len[s] == len) && (kv_key[s] == key);
  endfunction

  // Walk forward from home until a match, an empty slot or one full turn.
  function automatic bit probe_ring(int home, logic [63:0] key, int len, output int at);
    int s;
    s = home;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!kv_valid[s]) begin
        at = s;
        return 1'b0;
      end
      if (key_at(s, key, len)) begin
        at = s;
        return 1'b1;
      end
      s = (s + 1) % TABLE_SLOTS;
    end
    at = TABLE_SLOTS;
    return 1'b0;
  endfunction

  // Applies one request to the shadow table and returns the response it must give.
  function automatic lpht_pkg::lpht_rsp_t kv_response(lpht_pkg::lpht_req_t r);
    lpht_pkg::lpht_rsp_t rsp;
    logic [63:0] key;
    int          len;
    int          home;
    int          at;
    int          s;
    bit          hit;
    rsp  = '0;
    len  = (r.key_length > KEY_BYTES) ? KEY_BYTES : int'(r.key_length);
    key  = r.key_bytes;
    if (len < 8) key &= (64'd1 << (8 * len)) - 64'd1;
    home = key_home(key, len);
    hit  = probe_ring(home, key, len, at);
    case (r.mode) inside
      lpht_pkg::MODE_ADD: begin
        if (hit) begin
          kv_val[at] = r.new_value;
          rsp.found  = 1'b1;
        end else if (kv_count >= TABLE_SLOTS || at >= TABLE_SLOTS) begin
          rsp.status = lpht_pkg::STATUS_FULL;
        end else begin
          kv_valid[at] = 1'b1;
          kv_key[at]   = key;
          kv_len[at]   = 4'(len);
          kv_val[at]   = r.new_value;
          kv_count++;
        end
      end
      lpht_pkg::MODE_EXISTS, lpht_pkg::MODE_GET: begin
        if (hit) begin
          rsp.found = 1'b1;
          if (r.mode == lpht_pkg::MODE_GET) rsp.read_value = kv_val[at];
        end else begin
          rsp.status = lpht_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
        // Remove looks at the whole ring and skips over empty slots.
        rsp.status = lpht_pkg::STATUS_NOT_FOUND;
        s = home;
        for (int n = 0; n < TABLE_SLOTS && !rsp.found; n++) begin
          if (key_at(s, key, len)) begin
            kv_valid[s] = 1'b0;
            if (kv_count > 0) kv_count--;
            rsp.status = lpht_pkg::STATUS_OK;
            rsp.found  = 1'b1;
          end
          s = (s + 1) % TABLE_SLOTS;
        end
      end
    endcase
    rsp.entry_count = 11'(kv_count);
    return rsp;
  endfunction

  task automatic push_req(lpht_pkg::lpht_mode_e mode, logic [63:0] key, logic [3:0] len,
                          logic [31:0] value);
    lpht_pkg::lpht_req_t r;
    r.mode       = mode;
    r.key_bytes  = key;
    r.key_length = len;
    r.new_value  = value;
    pending_reqs.push_back(r);
  endtask

  // Short keys with a low first byte pile up on the same few home slots.
  task automatic refresh_pool_entry(int p);
    pool_key[p] = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2: begin
        pool_len[p]      = 4'd1;
        pool_key[p][7:0] = 8'(16 * $urandom_range(3) + $urandom_range(2));
      end
      3:       pool_len[p] = 4'($urandom_range(KEY_BYTES + 1, 15));
      default: pool_len[p] = 4'($urandom_range(KEY_BYTES));
    endcase
  endtask

  task automatic build_directed();
    // Lookups and removal on an empty table.
    push_req(lpht_pkg::MODE_GET,    64'h1234, 4'd2, 32'd7);
    push_req(lpht_pkg::MODE_EXISTS, 64'h1234, 4'd2, 32'd0);
    push_req(lpht_pkg::MODE_REMOVE, 64'h1234, 4'd2, 32'd0);
    // Empty key, and the widest key reached through an over-long length.
    push_req(lpht_pkg::MODE_ADD,    '1,       4'd0, 32'h7FFF_FFFF);
    push_req(lpht_pkg::MODE_GET,    64'h0,    4'd0, 32'd0);
    push_req(lpht_pkg::MODE_ADD,    '1,       4'd8, 32'h8000_0000);
    push_req(lpht_pkg::MODE_ADD,    '1,       4'd15, 32'h0000_0001);
    push_req(lpht_pkg::MODE_GET,    '1,       4'd12, 32'd0);
    // Bytes past the length are ignored by hash and compare.
    push_req(lpht_pkg::MODE_ADD,    64'hDEAD_BEEF_0063_6261, 4'd3, 32'd5);
    push_req(lpht_pkg::MODE_EXISTS, 64'h0123_4567_8963_6261, 4'd3, 32'd0);
    push_req(lpht_pkg::MODE_GET,    64'hFFFF_FFFF_FF63_6261, 4'd3, 32'd0);
    // A zero byte inside the length is a real byte, so lengths must agree.
    push_req(lpht_pkg::MODE_ADD,    64'h0,    4'd2, 32'hFFFF_FFFF);
    push_req(lpht_pkg::MODE_EXISTS, 64'h0,    4'd1, 32'd0);
    // Two keys on the same home slot, then a gap that hides the second one.
    push_req(lpht_pkg::MODE_ADD,    64'h01,   4'd1, 32'd10);
    push_req(lpht_pkg::MODE_ADD,    64'h11,   4'd1, 32'd11);
    push_req(lpht_pkg::MODE_REMOVE, 64'h01,   4'd1, 32'd0);
    push_req(lpht_pkg::MODE_EXISTS, 64'h11,   4'd1, 32'd0);
    push_req(lpht_pkg::MODE_ADD,    64'h11,   4'd1, 32'd12);
    push_req(lpht_pkg::MODE_GET,    64'h11,   4'd1, 32'd0);
    push_req(lpht_pkg::MODE_REMOVE, 64'h11,   4'd1, 32'd0);
    push_req(lpht_pkg::MODE_GET,    64'h11,   4'd1, 32'd0);
    push_req(lpht_pkg::MODE_REMOVE, 64'h11,   4'd1, 32'd0);
    push_req(lpht_pkg::MODE_GET,    64'h11,   4'd1, 32'd0);
    push_req(lpht_pkg::MODE_REMOVE, 64'h11,   4'd1, 32'd0);
  endtask

  // Bursts with a changing mix of adds, so the table fills up and drains again.
  task automatic build_random_traffic();
    int          made;
    int          burst;
    int          add_pct;
    int          window;
    int          pick;
    logic [63:0] key;
    logic [63:0] mask;
    logic [3:0]  len;
    lpht_pkg::lpht_mode_e mode;
    made = 0;
    for (int p = 0; p < POOL_DEPTH; p++) refresh_pool_entry(p);
    while (made < RANDOM_ITEMS) begin
      for (int n = $urandom_range(8); n > 0; n--) begin
        refresh_pool_entry($urandom_range(POOL_DEPTH - 1));
      end
      burst  = $urandom_range(30, 90);
      window = $urandom_range(4, POOL_DEPTH);
      case ($urandom_range(2))
        0:       add_pct = 15;
        1:       add_pct = 45;
        default: add_pct = 75;
      endcase
      for (int n = 0; n < burst; n++) begin
        if ($urandom_range(99) < add_pct) mode = lpht_pkg::MODE_ADD;
        else mode = lpht_pkg::lpht_mode_e'($urandom_range(1, 3));
        if ($urandom_range(19) == 0) begin
          key = {$urandom, $urandom};
          len = 4'($urandom_range(15));
        end else begin
          pick = $urandom_range(window - 1);
          key  = pool_key[pick];
          len  = pool_len[pick];
          if (len >= KEY_BYTES) begin
            if ($urandom_range(3) == 0) len = 4'($urandom_range(KEY_BYTES, 15));
          end else begin
            // Fresh junk above the key on every use.
            mask = (64'd1 << (8 * len)) - 64'd1;
            key  = (key & mask) | ({$urandom, $urandom} & ~mask);
          end
        end
        push_req(mode, key, len, $urandom);
        made++;
      end
    end
  endtask

  task automatic report_field(string name, logic [31:0] exp, logic [31:0] act);
    error_count++;
    $display("%0t: %s expected %0h, got %0h", $time, name, exp, act);
  endtask

  task automatic check_response(lpht_pkg::lpht_rsp_t exp, lpht_pkg::lpht_rsp_t act);
    if (act.status !== exp.status) begin
      report_field("status", 32'(exp.status), 32'(act.status));
    end
    if (act.found !== exp.found) begin
      report_field("found", 32'(exp.found), 32'(act.found));
    end
    if (act.read_value !== exp.read_value) begin
      report_field("read_value", exp.read_value, act.read_value);
    end
    if (act.entry_count !== exp.entry_count) begin
      report_field("entry_count", 32'(exp.entry_count), 32'(act.entry_count));
    end
  endtask

  // Request driver: holds a stalled request, otherwise sends the next or idles.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !taken_last)) begin
      if (pending_reqs.size() > 0 && (calm_phase || $urandom_range(99) >= IDLE_PCT)) begin
        in_req_i   <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Response back-pressure.
  always @(negedge clk_i) begin
    out_stall_i <= !calm_phase && ($urandom_range(99) < IDLE_PCT);
  end

  // Monitor: predicts on each accepted request and checks each accepted response.
  always @(posedge clk_i) begin
    taken_last = rst_ni && in_valid_i && !in_stall_o;
    if (taken_last) begin
      expected_rsps.push_back(kv_response(in_req_i));
      req_count++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        error_count++;
        $display("%0t: response %0h with none expected", $time, out_rsp_o);
      end else begin
        check_response(expected_rsps.pop_front(), out_rsp_o);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < TABLE_SLOTS; s++) kv_valid[s] = 1'b0;
    build_directed();
    build_random_traffic();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    // Let every request go out, every response come back, then a quiet tail.
    while (pending_reqs.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_rsps.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
